// ===== rtl/fcbl_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbl_pkg
// Shared types, constants and helpers of the freezer cartridge bus logic.
// ----------------------------------------------------------------------------
package fcbl_pkg;

    // sizing
    localparam int RAM_DEPTH     = 128;
    localparam int FREEZE_WRITES = 3;
    localparam int ROM_ADDR_BITS = 14;

    localparam int RAM_IDX_W   = $clog2(RAM_DEPTH);
    localparam int ROM_OUT_W   = 14;
    localparam int ROM_KEEP_W  = (ROM_ADDR_BITS < ROM_OUT_W) ? ROM_ADDR_BITS : ROM_OUT_W;
    localparam int FREEZE_W    = 3;

    // bus cycle kinds
    typedef enum logic [1:0] {
        FUNC_VIDEO_RD = 2'd0,
        FUNC_CPU_RD   = 2'd1,
        FUNC_CPU_WR   = 2'd2,
        FUNC_UNUSED   = 2'd3
    } func_t;

    // driven data sources
    localparam logic [1:0] SRC_ROM  = 2'd0;
    localparam logic [1:0] SRC_RAM  = 2'd1;
    localparam logic [1:0] SRC_MODE = 2'd2;

    // memory configurations
    localparam logic [1:0] MODE_16K     = 2'd0;
    localparam logic [1:0] MODE_8K      = 2'd1;
    localparam logic [1:0] MODE_ULTIMAX = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    // one host bus cycle
    typedef struct packed {
        logic [1:0]  func;
        logic        roml_n;
        logic        romh_n;
        logic        io1_n;
        logic        io2_n;
        logic        button;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
    } in_item_t;

    // answer to one bus cycle
    typedef struct packed {
        logic        drive;
        logic [1:0]  source;
        logic [7:0]  read_data;
        logic [13:0] rom_addr;
        logic [1:0]  mode;
        logic        led_on;
        logic        nmi_low;
    } out_item_t;

    // scratch ram access from the decoder
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [RAM_IDX_W-1:0] idx;
        logic [7:0]           wdata;
    } ram_ctrl_t;

    // ram index: low seven address bits folded into the ram depth
    // restoring compare and subtract, three steps cover depths down to 16
    function automatic logic [RAM_IDX_W-1:0] ram_index(input logic [6:0] addr7);
        logic [9:0] rem;
        rem = {3'b000, addr7};
        if (rem >= 10'(RAM_DEPTH * 4))
            rem = rem - 10'(RAM_DEPTH * 4);
        if (rem >= 10'(RAM_DEPTH * 2))
            rem = rem - 10'(RAM_DEPTH * 2);
        if (rem >= 10'(RAM_DEPTH))
            rem = rem - 10'(RAM_DEPTH);
        return rem[RAM_IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/fcbl_ram.sv =====
// ----------------------------------------------------------------------------
// fcbl_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fcbl_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fcbl_core.sv =====
// ----------------------------------------------------------------------------
// fcbl_core
// Bus cycle decoder and cartridge state: mode, button, NMI and freeze count.
// ----------------------------------------------------------------------------
module fcbl_core
    import fcbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    output out_item_t result,
    output ram_ctrl_t ram_ctrl
);

    logic [1:0]          mode_reg, mode_next;
    logic                button_held_reg, button_held_next;
    logic                nmi_reg, nmi_next;
    logic [FREEZE_W-1:0] freeze_count_reg, freeze_count_next;

    logic roml, romh, io1, io2;
    logic drive;
    logic [1:0] source;
    logic [FREEZE_W-1:0] count_dec;

    assign roml = !item.roml_n;
    assign romh = !item.romh_n;
    assign io1  = !item.io1_n;
    assign io2  = !item.io2_n;
    assign count_dec = freeze_count_reg - FREEZE_W'(1);

    // decode of one bus cycle
    always_comb
    begin
        mode_next         = mode_reg;
        button_held_next  = button_held_reg;
        nmi_next          = nmi_reg;
        freeze_count_next = freeze_count_reg;
        drive             = 1'b0;
        source            = SRC_ROM;
        ram_ctrl.we       = 1'b0;
        ram_ctrl.re       = 1'b0;
        ram_ctrl.idx      = ram_index(item.bus_addr[6:0]);
        ram_ctrl.wdata    = item.bus_data;

        unique case (func_t'(item.func))
            FUNC_VIDEO_RD:
            begin
                drive = roml || romh;
            end
            FUNC_CPU_RD:
            begin
                if (io1 || roml || romh)
                begin
                    drive = 1'b1;
                    if (io1)
                        mode_next = (item.bus_addr[1:0] & 2'b10) | MODE_8K;
                end
                else if (io2)
                begin
                    drive = 1'b1;
                    if (!item.bus_addr[7])
                    begin
                        source      = SRC_RAM;
                        ram_ctrl.re = step;
                    end
                    else
                        source = SRC_MODE;
                end
                else if (item.button)
                    button_held_next = 1'b1;
                else if (button_held_reg)
                begin
                    // release after a press starts a freeze
                    nmi_next          = 1'b1;
                    button_held_next  = 1'b0;
                    freeze_count_next = FREEZE_W'(FREEZE_WRITES);
                end
            end
            FUNC_CPU_WR:
            begin
                if (freeze_count_reg != '0)
                begin
                    freeze_count_next = count_dec;
                    if (count_dec == '0)
                        mode_next = MODE_ULTIMAX;
                end
                if (io1)
                    mode_next = item.bus_addr[1:0] & 2'b10;
                else if (io2)
                begin
                    ram_ctrl.we = step && !item.bus_addr[7];
                    nmi_next    = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // state update on each processed cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_16K;
            button_held_reg  <= 1'b0;
            nmi_reg          <= 1'b0;
            freeze_count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg         <= mode_next;
            button_held_reg  <= button_held_next;
            nmi_reg          <= nmi_next;
            freeze_count_reg <= freeze_count_next;
        end
    end

    // result fields, ram byte is merged in after the read register
    always_comb
    begin
        result.drive     = drive;
        result.source    = source;
        result.read_data = (source == SRC_MODE) ? {mode_reg, 6'b000000} : 8'h00;
        result.rom_addr  = ROM_OUT_W'(item.bus_addr[ROM_KEEP_W-1:0]);
        result.mode      = mode_next;
        result.led_on    = (mode_next != MODE_NONE);
        result.nmi_low   = nmi_next;
    end

    // freeze count never exceeds its start value
    a_freeze_range: assert property (@(posedge clk) disable iff (!rst_n)
        freeze_count_reg <= FREEZE_W'(FREEZE_WRITES))
        else $error("freeze count out of range");

    // starting a freeze pulls nmi low
    a_freeze_nmi: assert property (@(posedge clk) disable iff (!rst_n)
        step && freeze_count_next == FREEZE_W'(FREEZE_WRITES)
            && freeze_count_reg != FREEZE_W'(FREEZE_WRITES) |=> nmi_reg)
        else $error("freeze started without nmi");

    // ram is never read and written by one cycle
    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_ctrl.we && ram_ctrl.re))
        else $error("ram read and write together");

endmodule

// ===== rtl/freezer_cartridge_bus_logic_top.sv =====
// ----------------------------------------------------------------------------
// freezer_cartridge_bus_logic_top
// Freezer cartridge bus logic: input register, decoder, scratch RAM, result.
// ----------------------------------------------------------------------------
// result path: an input transfer lands in the input register, and its result in
// the result register, from which the result transfer is taken
// throughput: one bus cycle per clock while out_ready holds, set by the single decode stage
// between the input register and the result register
// reset: asynchronous active-low rst_n clears valid flags, mode, button,
// nmi and freeze count; scratch ram contents stay undefined until written
module freezer_cartridge_bus_logic_top
    import fcbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    out_item_t result;
    ram_ctrl_t ram_ctrl;
    logic [7:0] ram_rdata;

    // stage moves when the result register is free or being emptied
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_item_reg <= in_data;
    end

    // decoder and state
    fcbl_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_valid_reg && advance),
        .item     (in_item_reg),
        .result   (result),
        .ram_ctrl (ram_ctrl)
    );

    // scratch ram
    fcbl_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (ram_ctrl.we),
        .waddr (ram_ctrl.idx),
        .wdata (ram_ctrl.wdata),
        .re    (ram_ctrl.re),
        .raddr (ram_ctrl.idx),
        .rdata (ram_rdata)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_item_reg <= result;
    end

    // ram byte joins the result after its read register
    always_comb
    begin
        out_data = out_item_reg;
        if (out_item_reg.source == SRC_RAM)
            out_data.read_data = ram_rdata;
    end

    assign out_valid = out_valid_reg;

    // a stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_item_reg))
        else $error("result changed while stalled");

    // empty input register always takes a transfer
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> in_ready)
        else $error("input stalled while empty");

    // an undriven cycle answers rom source and zero data
    a_undriven: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.drive |-> out_data.source == SRC_ROM
            && out_data.read_data == 8'h00)
        else $error("undriven cycle with data");

    // led follows the mode
    a_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.led_on == (out_data.mode != MODE_NONE))
        else $error("led does not follow mode");

endmodule

// ===== dv/tb_freezer_cartridge_bus_logic_top.sv =====
// ----------------------------------------------------------------------------
// tb_freezer_cartridge_bus_logic_top
// Self-checking bench for the freezer cartridge bus logic. A short table of
// bus cycles covers the select extremes, RAM readback, mode changes and the
// freeze sequence. Random bus cycles follow, biased towards button press and
// release runs and the writes after them. Each answer is compared field by
// field against a typed answer or an in-bench model of the mode, scratch RAM,
// button and NMI state, with random gaps and stalls on both sides of the block.
// ----------------------------------------------------------------------------
module tb_freezer_cartridge_bus_logic_top;
    import fcbl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_CYCLES = 1525;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_PRINTS  = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    // one directed table row, answer typed in only where obvious
    typedef struct {
        in_item_t  cyc;
        bit        typed;
        out_item_t ans;
    } bus_row_t;

    bus_row_t  bus_rows[$];
    out_item_t answer_q[$];

    // model state of the cartridge logic
    logic [1:0] mdl_mode        = MODE_16K;
    logic [7:0] mdl_ram[RAM_DEPTH];
    bit         mdl_ram_written[RAM_DEPTH];
    int         written_idx[$];
    logic       mdl_btn_held    = 1'b0;
    logic       mdl_nmi         = 1'b0;
    logic [2:0] mdl_freeze_left = '0;

    // run control shared between processes
    bit tx_calm  = 1'b0;
    bit rx_calm  = 1'b0;
    bit hold_req = 1'b0;

    int mismatches  = 0;
    int n_cycles    = 0;
    int n_answers   = 0;
    int n_freezes   = 0;
    int n_forced    = 0;
    int n_ram_reads = 0;

    freezer_cartridge_bus_logic_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always #6 clk = ~clk;

    // mismatch report, one line each
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
    endtask

    // bus cycle constructors for the table
    function automatic in_item_t cyc(input logic [1:0] func, input logic roml_n,
                                     input logic romh_n, input logic io1_n,
                                     input logic io2_n, input logic button,
                                     input logic [15:0] addr, input logic [7:0] data);
        in_item_t c;
        c.func     = func;
        c.roml_n   = roml_n;
        c.romh_n   = romh_n;
        c.io1_n    = io1_n;
        c.io2_n    = io2_n;
        c.button   = button;
        c.bus_addr = addr;
        c.bus_data = data;
        return c;
    endfunction

    function automatic out_item_t ans(input logic drive, input logic [1:0] source,
                                      input logic [7:0] rdata, input logic [13:0] rom,
                                      input logic [1:0] mode, input logic led,
                                      input logic nmi);
        out_item_t a;
        a.drive     = drive;
        a.source    = source;
        a.read_data = rdata;
        a.rom_addr  = rom;
        a.mode      = mode;
        a.led_on    = led;
        a.nmi_low   = nmi;
        return a;
    endfunction

    // predicted answer of one bus cycle, advances the model state
    task automatic predict_bus_answer(input in_item_t c, output out_item_t r);
        int idx;
        r   = '0;
        idx = int'(c.bus_addr[6:0]) % RAM_DEPTH;
        case (func_t'(c.func))
            FUNC_VIDEO_RD:
            begin
                r.drive = !c.roml_n || !c.romh_n;
            end
            FUNC_CPU_RD:
            begin
                if (!c.io1_n || !c.roml_n || !c.romh_n)
                begin
                    r.drive = 1'b1;
                    if (!c.io1_n)
                        mdl_mode = {c.bus_addr[1], 1'b1};
                end
                else if (!c.io2_n)
                begin
                    r.drive = 1'b1;
                    if (!c.bus_addr[7])
                    begin
                        r.source    = SRC_RAM;
                        r.read_data = mdl_ram[idx];
                        n_ram_reads++;
                    end
                    else
                    begin
                        r.source    = SRC_MODE;
                        r.read_data = {mdl_mode, 6'b000000};
                    end
                end
                else if (c.button)
                begin
                    mdl_btn_held = 1'b1;
                end
                else if (mdl_btn_held)
                begin
                    mdl_nmi         = 1'b1;
                    mdl_btn_held    = 1'b0;
                    mdl_freeze_left = 3'(FREEZE_WRITES);
                    n_freezes++;
                end
            end
            FUNC_CPU_WR:
            begin
                // freeze countdown comes before the decode of this write
                if (mdl_freeze_left != 0)
                begin
                    mdl_freeze_left = mdl_freeze_left - 3'd1;
                    if (mdl_freeze_left == 0)
                    begin
                        mdl_mode = MODE_ULTIMAX;
                        n_forced++;
                    end
                end
                if (!c.io1_n)
                begin
                    mdl_mode = {c.bus_addr[1], 1'b0};
                end
                else if (!c.io2_n)
                begin
                    if (!c.bus_addr[7])
                    begin
                        mdl_ram[idx] = c.bus_data;
                        if (!mdl_ram_written[idx])
                        begin
                            mdl_ram_written[idx] = 1'b1;
                            written_idx.push_back(idx);
                        end
                    end
                    mdl_nmi = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        r.rom_addr = c.bus_addr[13:0] & 14'((1 << ROM_ADDR_BITS) - 1);
        r.mode     = mdl_mode;
        r.led_on   = (mdl_mode != MODE_NONE);
        r.nmi_low  = mdl_nmi;
    endtask

    // steer ram reads away from entries never written
    function automatic in_item_t avoid_blank_read(input in_item_t c);
        in_item_t f;
        f = c;
        if (c.func == FUNC_CPU_RD && c.io1_n && c.roml_n && c.romh_n && !c.io2_n
            && !c.bus_addr[7] && !mdl_ram_written[int'(c.bus_addr[6:0]) % RAM_DEPTH])
        begin
            if (written_idx.size() != 0)
                f.bus_addr[6:0] = 7'(written_idx[$urandom_range(0, written_idx.size() - 1)]);
            else
                f.bus_addr[7] = 1'b1;
        end
        return f;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // random bus cycle, selects low about a quarter of the time
    function automatic in_item_t rand_cycle();
        in_item_t c;
        int       k;
        k = $urandom_range(0, 19);
        if (k < 4)
            c.func = FUNC_VIDEO_RD;
        else if (k < 12)
            c.func = FUNC_CPU_RD;
        else if (k < 19)
            c.func = FUNC_CPU_WR;
        else
            c.func = FUNC_UNUSED;
        c.roml_n   = ($urandom_range(0, 3) != 0);
        c.romh_n   = ($urandom_range(0, 3) != 0);
        c.io1_n    = ($urandom_range(0, 3) != 0);
        c.io2_n    = ($urandom_range(0, 3) != 0);
        c.button   = 1'($urandom_range(0, 1));
        c.bus_addr = 16'($urandom);
        if ($urandom_range(0, 2) == 0)
            c.bus_addr[6:4] = 3'b000;
        c.bus_data = 8'($urandom);
        return c;
    endfunction

    // processor read with nothing selected, samples the button
    function automatic in_item_t quiet_read(input logic btn);
        in_item_t c;
        c        = rand_cycle();
        c.func   = FUNC_CPU_RD;
        c.roml_n = 1'b1;
        c.romh_n = 1'b1;
        c.io1_n  = 1'b1;
        c.io2_n  = 1'b1;
        c.button = btn;
        return c;
    endfunction

    // one input transfer, then the typed or model answer is queued
    task automatic send_cycle(input in_item_t c, input bit typed, input out_item_t a);
        int        gap;
        in_item_t  f;
        out_item_t p;
        gap = tx_calm ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        f = avoid_blank_read(c);
        in_valid <= 1'b1;
        in_data  <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_bus_answer(f, p);
        answer_q.push_back(typed ? a : p);
        n_cycles++;
    endtask

    // result side: compare each transfer with the oldest answer
    always @(posedge clk)
    begin : answer_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (answer_q.size() == 0)
            begin
                report_mismatch("answer with none pending", out_data, 0);
            end
            else
            begin
                want = answer_q.pop_front();
                n_answers++;
                if (out_data.drive !== want.drive)
                    report_mismatch("drive", out_data.drive, want.drive);
                if (out_data.source !== want.source)
                    report_mismatch("source", out_data.source, want.source);
                if (out_data.read_data !== want.read_data)
                    report_mismatch("read_data", out_data.read_data, want.read_data);
                if (out_data.rom_addr !== want.rom_addr)
                    report_mismatch("rom_addr", out_data.rom_addr, want.rom_addr);
                if (out_data.mode !== want.mode)
                    report_mismatch("mode", out_data.mode, want.mode);
                if (out_data.led_on !== want.led_on)
                    report_mismatch("led_on", out_data.led_on, want.led_on);
                if (out_data.nmi_low !== want.nmi_low)
                    report_mismatch("nmi_low", out_data.nmi_low, want.nmi_low);
            end
        end
    end

    // result side ready: random stalls, calm stretches, one long hold-off
    initial
    begin : result_sink
        bit stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                stall = ($urandom_range(0, 3) == 0);
                out_ready <= !stall;
                if (stall)
                    repeat (idle_len() + 1) @(posedge clk);
                else
                    repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // overall time limit
    initial
    begin : watchdog
        #20ms;
        $display("timeout with %0d answers pending", answer_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        in_item_t burst_q[$];
        in_item_t c;
        int       n_sent;
        int       k;

        // directed table
        bus_rows.push_back('{cyc(FUNC_VIDEO_RD, 0, 1, 1, 1, 0, 16'hffff, 8'h00), 1'b1,
                             ans(1, SRC_ROM, 8'h00, 14'h3fff, MODE_16K, 1, 0)});
        bus_rows.push_back('{cyc(FUNC_VIDEO_RD, 1, 1, 0, 0, 1, 16'h0000, 8'hff), 1'b1,
                             ans(0, SRC_ROM, 8'h00, 14'h0000, MODE_16K, 1, 0)});
        bus_rows.push_back('{cyc(FUNC_UNUSED, 0, 0, 0, 0, 1, 16'h1234, 8'h5a), 1'b1,
                             ans(0, SRC_ROM, 8'h00, 14'h1234, MODE_16K, 1, 0)});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 0, 0, 16'h007f, 8'hff), 1'b1,
                             ans(0, SRC_ROM, 8'h00, 14'h007f, MODE_16K, 1, 0)});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 0, 1, 16'hc000, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 0, 0, 16'h0055, 8'ha5), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 0, 0, 16'h007f, 8'h00), 1'b1,
                             ans(1, SRC_RAM, 8'hff, 14'h007f, MODE_16K, 1, 0)});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 0, 0, 16'h0000, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 0, 1, 16'hff55, 8'h00), 1'b0, '0});
        // first i/o read selects mode from address bit 1
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 0, 1, 0, 16'h0002, 8'h00), 1'b1,
                             ans(1, SRC_ROM, 8'h00, 14'h0002, MODE_NONE, 0, 0)});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 0, 0, 16'h0080, 8'h00), 1'b1,
                             ans(1, SRC_MODE, 8'hc0, 14'h0080, MODE_NONE, 0, 0)});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 0, 0, 0, 16'hfffd, 8'h99), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 0, 1, 0, 16'h0001, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 0, 0, 16'hff80, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 0, 1, 0, 0, 16'h3fff, 8'h00), 1'b0, '0});
        // release with no press before it
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 1, 0, 16'h0100, 8'h00), 1'b0, '0});
        // press, release, then the freeze writes
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 1, 1, 16'h0200, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 1, 0, 16'h0300, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 1, 0, 16'h0400, 8'h77), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 0, 0, 16'h0080, 8'h33), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 1, 0, 16'h0500, 8'h00), 1'b0, '0});
        // forced ultimax overridden by a first i/o write on the same cycle
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 1, 1, 16'h0600, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_RD, 1, 1, 1, 1, 0, 16'h0700, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 1, 0, 16'h0800, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 1, 1, 0, 16'h0900, 8'h00), 1'b0, '0});
        bus_rows.push_back('{cyc(FUNC_CPU_WR, 1, 1, 0, 1, 0, 16'h0000, 8'h00), 1'b0, '0});

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (bus_rows[i])
            send_cycle(bus_rows[i].cyc, bus_rows[i].typed, bus_rows[i].ans);

        // random part, freeze runs mixed with single cycles
        n_sent = 0;
        while (n_sent < RAND_CYCLES)
        begin
            if (burst_q.size() == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    k = $urandom_range(1, 3);
                    repeat (k)
                        burst_q.push_back(quiet_read(1'b1));
                    if ($urandom_range(0, 4) == 0)
                        burst_q.push_back(rand_cycle());
                    burst_q.push_back(quiet_read(1'b0));
                    k = $urandom_range(0, 5);
                    repeat (k)
                    begin
                        c = rand_cycle();
                        if ($urandom_range(0, 3) != 0)
                            c.func = FUNC_CPU_WR;
                        burst_q.push_back(c);
                    end
                end
                else
                begin
                    burst_q.push_back(rand_cycle());
                end
            end
            c = burst_q.pop_front();

            // phases: back to back, long result hold-off, drain pause
            if (n_sent == 400)
            begin
                tx_calm = 1'b1;
                rx_calm = 1'b1;
            end
            if (n_sent == 700)
                hold_req = 1'b1;
            if (n_sent == 900)
            begin
                tx_calm = 1'b0;
                rx_calm = 1'b0;
            end
            if (n_sent == 1100)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (answer_q.size() != 0);
            end

            send_cycle(c, 1'b0, '0);
            n_sent++;
        end

        // drain
        in_valid <= 1'b0;
        for (int i = 0; i < 5000 && answer_q.size() != 0; i++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (answer_q.size() != 0)
            report_mismatch("answers never delivered", answer_q.size(), 0);

        $display("%0d bus cycles sent, %0d answers checked, %0d mismatches",
                 n_cycles, n_answers, mismatches);
        $display("%0d freezes started, %0d forced ultimax, %0d scratch ram readbacks",
                 n_freezes, n_forced, n_ram_reads);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== freezer_cartridge_bus_logic_top.f =====
rtl/fcbl_pkg.sv
rtl/fcbl_ram.sv
rtl/fcbl_core.sv
rtl/freezer_cartridge_bus_logic_top.sv
dv/tb_freezer_cartridge_bus_logic_top.sv
